// ===== sv/assert_macros.svh =====
// Assertion macros for the checker file of this block.
// Depends on nothing; take it in with an include of the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is asserted.
`define SPMQ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Concurrent assertion that is also checked while reset is asserted.
`define SPMQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== sv/spmq_pkg.sv =====
// Package of the strict-priority multi-level queue: sizes, codes and helpers.
// Used by every module of the block but the entry memory; depends on nothing.
package spmq_pkg;

    localparam int LEVELS          = 8;
    localparam int DEPTH_PER_LEVEL = 16;
    localparam int HANDLE_WIDTH    = 16;

    localparam int MODE_W    = 2;
    localparam int PRIO_W    = 8;
    localparam int PAYLOAD_W = 16;
    localparam int STATUS_W  = 2;
    localparam int LEVEL_W   = 3;

    // Only the low handle bits of the payload are stored.
    localparam int STORE_W = (HANDLE_WIDTH < PAYLOAD_W) ? HANDLE_WIDTH : PAYLOAD_W;
    localparam int LVL_W   = $clog2(LEVELS);
    localparam int PTR_W   = $clog2(DEPTH_PER_LEVEL);
    localparam int CNT_W   = $clog2(DEPTH_PER_LEVEL + 1);
    localparam int ENTRIES = LEVELS * DEPTH_PER_LEVEL;
    localparam int ADDR_W  = $clog2(ENTRIES);

    typedef enum logic [MODE_W-1:0] {
        MODE_INSERT = 2'd0,
        MODE_GET    = 2'd1,
        MODE_CLEAR  = 2'd2
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_FROZEN = 2'd1,
        ST_FULL   = 2'd2,
        ST_EMPTY  = 2'd3
    } t_status;

    // Requests from the control FSM to the level table.
    typedef struct packed {
        logic             push;
        logic             pop;
        logic             clear;
        logic [LVL_W-1:0] push_lvl;
    } t_lq_req;

    // Lookup results of the level table for the current transaction.
    typedef struct packed {
        logic             push_full;
        logic [PTR_W-1:0] push_slot;
        logic             pop_hit;
        logic [LVL_W-1:0] pop_lvl;
        logic [PTR_W-1:0] pop_slot;
    } t_lq_info;

    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH_PER_LEVEL - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [ADDR_W-1:0] entry_addr(input logic [LVL_W-1:0] lvl,
                                                     input logic [PTR_W-1:0] slot);
        return ADDR_W'(lvl) * ADDR_W'(DEPTH_PER_LEVEL) + ADDR_W'(slot);
    endfunction

endpackage

// ===== sv/spmq_entry_ram.sv =====
// Simple dual-port entry memory with registered read data.
// Generic; depends on nothing.
module spmq_entry_ram #(
    parameter int DATA_W = 16,
    parameter int DEPTH  = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DATA_W-1:0]        i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DATA_W-1:0]        o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/spmq_level_table.sv =====
// Per-level head, tail and fill count of the queue, plus the highest-level search.
// Depends on spmq_pkg.
module spmq_level_table (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  spmq_pkg::t_lq_req i_req,
    output spmq_pkg::t_lq_info o_info
);

    logic [spmq_pkg::PTR_W-1:0] r_head  [spmq_pkg::LEVELS];
    logic [spmq_pkg::PTR_W-1:0] r_tail  [spmq_pkg::LEVELS];
    logic [spmq_pkg::CNT_W-1:0] r_count [spmq_pkg::LEVELS];

    logic                       hit;
    logic [spmq_pkg::LVL_W-1:0] top_lvl;

    // The last match wins, so the scan ends on the highest non-empty level.
    always_comb begin
        hit     = 1'b0;
        top_lvl = '0;
        for (int l = 0; l < spmq_pkg::LEVELS; l++) begin
            if (r_count[l] != '0) begin
                hit     = 1'b1;
                top_lvl = spmq_pkg::LVL_W'(l);
            end
        end
    end

    always_comb begin
        o_info.push_full = r_count[i_req.push_lvl] >= spmq_pkg::CNT_W'(spmq_pkg::DEPTH_PER_LEVEL);
        o_info.push_slot = r_tail[i_req.push_lvl];
        o_info.pop_hit   = hit;
        o_info.pop_lvl   = top_lvl;
        o_info.pop_slot  = r_head[top_lvl];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_req.clear) begin
            for (int l = 0; l < spmq_pkg::LEVELS; l++) begin
                r_head[l]  <= '0;
                r_tail[l]  <= '0;
                r_count[l] <= '0;
            end
        end else begin
            if (i_req.push) begin
                r_tail[i_req.push_lvl]  <= spmq_pkg::next_slot(r_tail[i_req.push_lvl]);
                r_count[i_req.push_lvl] <= r_count[i_req.push_lvl] + 1'b1;
            end
            if (i_req.pop) begin
                r_head[top_lvl]  <= spmq_pkg::next_slot(r_head[top_lvl]);
                r_count[top_lvl] <= r_count[top_lvl] - 1'b1;
            end
        end
    end

endmodule

// ===== sv/strict_priority_multi_queue.sv =====
// Strict-priority multi-level queue: one FIFO per level in a shared entry memory.
// Depends on spmq_pkg, spmq_entry_ram and spmq_level_table.
//
// Input channel (i_in_valid / o_in_ready) carries a mode, a priority and a
// handle. Insert puts the handle at the tail of its level (priorities above
// the top level go to the top level), get pops the oldest handle of the
// highest non-empty level, clear empties every level. Each transaction gives
// exactly one result on the output channel (o_out_valid / i_out_ready).
// Inserts, clears and failed gets return their result in the cycle after the
// transaction; a successful get returns it only after the read state, since the
// handle comes out of the entry memory through its registered read data.
// A new transaction is taken in the cycle the previous result leaves, so the
// block never works on more than one transaction at a time.
// The frozen register (i_cfg_we / i_cfg_wdata) rejects inserts while set.
// Reset empties all levels, clears frozen and drops o_out_valid; the entry
// memory itself is not cleared. While the receiver stalls, the result is held
// and o_in_ready stays low.
module strict_priority_multi_queue (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_wdata,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [spmq_pkg::MODE_W-1:0]   i_mode,
    input  logic [spmq_pkg::PRIO_W-1:0]   i_priority_req,
    input  logic [spmq_pkg::PAYLOAD_W-1:0] i_payload,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [spmq_pkg::STATUS_W-1:0] o_status,
    output logic [spmq_pkg::PAYLOAD_W-1:0] o_payload_out,
    output logic [spmq_pkg::LEVEL_W-1:0]  o_level_out
);

    typedef enum logic {S_IDLE, S_READ} t_state;

    t_state                         r_state, n_state;
    logic                           r_frozen;
    logic                           r_out_valid, n_out_valid;
    spmq_pkg::t_status              r_status, n_status;
    logic [spmq_pkg::PAYLOAD_W-1:0] r_payload_out, n_payload_out;
    logic [spmq_pkg::LEVEL_W-1:0]   r_level_out, n_level_out;

    spmq_pkg::t_lq_req              lq_req;
    spmq_pkg::t_lq_info             lq_info;
    logic                           accept;
    logic [spmq_pkg::LVL_W-1:0]     ins_lvl;
    logic                           ram_we, ram_re;
    logic [spmq_pkg::STORE_W-1:0]   ram_rdata;

    assign o_in_ready = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign accept     = i_in_valid && o_in_ready;

    assign ins_lvl = (i_priority_req >= spmq_pkg::PRIO_W'(spmq_pkg::LEVELS))
                   ? spmq_pkg::LVL_W'(spmq_pkg::LEVELS - 1)
                   : i_priority_req[spmq_pkg::LVL_W-1:0];

    always_comb begin
        n_state         = r_state;
        n_out_valid     = r_out_valid && !i_out_ready;
        n_status        = r_status;
        n_payload_out   = r_payload_out;
        n_level_out     = r_level_out;
        lq_req.push     = 1'b0;
        lq_req.pop      = 1'b0;
        lq_req.clear    = 1'b0;
        lq_req.push_lvl = ins_lvl;
        ram_we          = 1'b0;
        ram_re          = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_out_valid   = 1'b1;
                    n_status      = spmq_pkg::ST_OK;
                    n_payload_out = '0;
                    n_level_out   = '0;
                    case (spmq_pkg::t_mode'(i_mode))
                        spmq_pkg::MODE_INSERT: begin
                            if (r_frozen) begin
                                n_status = spmq_pkg::ST_FROZEN;
                            end else if (lq_info.push_full) begin
                                n_status = spmq_pkg::ST_FULL;
                            end else begin
                                lq_req.push = 1'b1;
                                ram_we      = 1'b1;
                            end
                        end
                        spmq_pkg::MODE_GET: begin
                            if (lq_info.pop_hit) begin
                                // The result waits for the memory read.
                                lq_req.pop  = 1'b1;
                                ram_re      = 1'b1;
                                n_out_valid = 1'b0;
                                n_level_out = spmq_pkg::LEVEL_W'(lq_info.pop_lvl);
                                n_state     = S_READ;
                            end else begin
                                n_status = spmq_pkg::ST_EMPTY;
                            end
                        end
                        spmq_pkg::MODE_CLEAR: begin
                            lq_req.clear = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_READ: begin
                n_out_valid   = 1'b1;
                n_payload_out = spmq_pkg::PAYLOAD_W'(ram_rdata);
                n_state       = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_frozen    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_frozen <= i_cfg_wdata;
            end
        end
        r_status      <= n_status;
        r_payload_out <= n_payload_out;
        r_level_out   <= n_level_out;
    end

    spmq_level_table u_level_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (lq_req),
        .o_info  (lq_info)
    );

    // A write and a read never fall in the same cycle: the FSM takes one
    // transaction at a time, so no forwarding is needed.
    spmq_entry_ram #(
        .DATA_W (spmq_pkg::STORE_W),
        .DEPTH  (spmq_pkg::ENTRIES)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (spmq_pkg::entry_addr(ins_lvl, lq_info.push_slot)),
        .i_wdata (i_payload[spmq_pkg::STORE_W-1:0]),
        .i_re    (ram_re),
        .i_raddr (spmq_pkg::entry_addr(lq_info.pop_lvl, lq_info.pop_slot)),
        .o_rdata (ram_rdata)
    );

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_payload_out = r_payload_out;
    assign o_level_out   = r_level_out;

endmodule

// ===== sv/spmq_checker.sv =====
// Port-level checker for the strict-priority queue, bound to the top level.
// Depends on spmq_pkg and assert_macros.svh.
`include "assert_macros.svh"

module spmq_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           o_in_ready,
    input logic [spmq_pkg::MODE_W-1:0]    i_mode,
    input logic                           o_out_valid,
    input logic                           i_out_ready,
    input logic [spmq_pkg::STATUS_W-1:0]  o_status,
    input logic [spmq_pkg::PAYLOAD_W-1:0] o_payload_out,
    input logic [spmq_pkg::LEVEL_W-1:0]   o_level_out
);

    logic in_txn;
    logic non_get;
    logic other_txn;
    logic get_txn;
    logic out_stall;
    logic out_fail;
    logic out_zero;
    logic busy;
    logic [spmq_pkg::STATUS_W+spmq_pkg::PAYLOAD_W+spmq_pkg::LEVEL_W:0] out_bus;

    assign in_txn    = i_in_valid && o_in_ready;
    assign non_get   = i_mode != spmq_pkg::MODE_GET;
    assign other_txn = in_txn && non_get;
    assign get_txn   = in_txn && !non_get;
    assign out_stall = o_out_valid && !i_out_ready;
    assign out_fail  = o_out_valid && (o_status != spmq_pkg::ST_OK);
    assign out_zero  = (o_payload_out == '0) && (o_level_out == '0);
    assign busy      = !o_in_ready;
    assign out_bus   = {o_out_valid, o_status, o_payload_out, o_level_out};

    // A stalled result keeps its valid and its fields.
    `SPMQ_ASSERT(a_out_hold, i_clk, i_rst_n, out_stall |=> $stable(out_bus), "result changed")

    // Every failed result carries zero payload and level.
    `SPMQ_ASSERT(a_fail_zero, i_clk, i_rst_n, out_fail |-> out_zero, "nonzero failed result")

    // Anything but a get answers in the very next cycle.
    `SPMQ_ASSERT(a_quick_result, i_clk, i_rst_n, other_txn |=> o_out_valid, "late result")

    // A get answers directly, or once the block has been busy with its memory read.
    `SPMQ_ASSERT(a_get, i_clk, i_rst_n, get_txn |=> o_out_valid or (busy ##1 o_out_valid), "late get")

    `SPMQ_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !o_out_valid, "result valid after reset")

endmodule

bind strict_priority_multi_queue spmq_checker u_spmq_checker (.*);
